@@ hw/rtl/repa_pkg.sv @@
// ============================================================================
// Root entry pool allocator package
// Shared constants, link and code types, and sequencer states.
// ============================================================================
package repa_pkg;

    // Pool geometry.
    localparam int POOL_SIZE         = 1024;
    localparam int IDX_W             = 10;
    localparam int LINK_W            = IDX_W + 1;
    localparam int BLK_W             = 5;
    localparam int ENTRIES_PER_BLOCK = 64;
    localparam int MAX_BLOCKS        = 16;

    // Blocks that fit wholly in the pool, capped by the block limit and by the counter.
    localparam int POOL_BLOCKS   = POOL_SIZE / ENTRIES_PER_BLOCK;
    localparam int CAP_BLOCKS    = (MAX_BLOCKS < POOL_BLOCKS) ? MAX_BLOCKS : POOL_BLOCKS;
    localparam int USABLE_BLOCKS = (CAP_BLOCKS > 31) ? 31 : CAP_BLOCKS;

    // Counter widths.
    localparam int CNT_W  = (ENTRIES_PER_BLOCK > 1) ? $clog2(ENTRIES_PER_BLOCK) : 1;
    localparam int STEP_W = $clog2(POOL_SIZE) + 1;

    // A link carries an entry index; the top bit set marks the end of a list.
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam link_t NULL_LINK = link_t'(1) << IDX_W;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EXHAUSTED  = 2'd1,
        STATUS_NOT_IN_USE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REFILL,
        ST_POP_RD,
        ST_POP_WR,
        ST_REL_HEAD_WR,
        ST_WALK,
        ST_UNLINK_WR,
        ST_UNLINK_FIN,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/root_entry_pool_allocator_unit.sv @@
// ============================================================================
// Root entry pool allocator
// Free list and in-use list linked through one next-pointer memory; allocate
// pops the free head, release unlinks an entry found by walking the in-use list.
// ============================================================================
//
//  Channel   Signals                              Direction
//  --------  -----------------------------------  ---------
//  request   in_valid/in_ready, opcode,           input
//            release_index
//  result    out_valid/out_ready, entry_index,    output
//            status, refilled
//
// Allocate from a non-empty free list reads the head's link, then pops the head; a
// fresh block is first linked in, one memory write per slot; a refused allocate goes
// straight to the result. Release at the in-use head reads its link and unlinks it;
// elsewhere it walks one link per read, then bridges or misses; one read port sets the pace.
// The link memory has no clearing pass; the block is ready right after reset.
// A request is taken while one result waits in the output register; a second result
// holds the sequencer in its final state until the output register drains.
module root_entry_pool_allocator_unit
    import repa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic [IDX_W-1:0] release_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] entry_index,
    output logic [1:0]       status,
    output logic             refilled
);

    // Link memory, one write and one registered read per cycle.
    link_t link_mem [POOL_SIZE];
    link_t link_rd_reg;
    logic  mem_we;
    idx_t  mem_waddr;
    link_t mem_wdata;
    idx_t  mem_raddr;

    // Sequencer and list state.
    state_t            state_reg,       state_next;
    link_t             free_head_reg,   free_head_next;
    link_t             used_head_reg,   used_head_next;
    logic [BLK_W-1:0]  blocks_reg,      blocks_next;
    idx_t              rel_idx_reg,     rel_idx_next;
    idx_t              slot_reg,        slot_next;
    logic [CNT_W-1:0]  cnt_reg,         cnt_next;
    link_t             prior_reg,       prior_next;
    logic [STEP_W-1:0] step_reg,        step_next;
    logic              rf_reg,          rf_next;
    idx_t              res_entry_reg,   res_entry_next;
    status_t           res_status_reg,  res_status_next;

    // Output register.
    logic              out_valid_reg,   out_valid_next;
    idx_t              out_entry_reg,   out_entry_next;
    status_t           out_status_reg,  out_status_next;
    logic              out_rf_reg,      out_rf_next;

    logic              accept;
    logic              out_free;
    link_t             nx;
    logic [STEP_W-1:0] step_inc;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign nx       = link_rd_reg;
    assign step_inc = step_reg + STEP_W'(1);

    // Link memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        link_rd_reg <= link_mem[mem_raddr];
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= NULL_LINK;
            used_head_reg  <= NULL_LINK;
            blocks_reg     <= '0;
            rel_idx_reg    <= '0;
            slot_reg       <= '0;
            cnt_reg        <= '0;
            prior_reg      <= NULL_LINK;
            step_reg       <= '0;
            rf_reg         <= 1'b0;
            res_entry_reg  <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_entry_reg  <= '0;
            out_status_reg <= STATUS_OK;
            out_rf_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            used_head_reg  <= used_head_next;
            blocks_reg     <= blocks_next;
            rel_idx_reg    <= rel_idx_next;
            slot_reg       <= slot_next;
            cnt_reg        <= cnt_next;
            prior_reg      <= prior_next;
            step_reg       <= step_next;
            rf_reg         <= rf_next;
            res_entry_reg  <= res_entry_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_entry_reg  <= out_entry_next;
            out_status_reg <= out_status_next;
            out_rf_reg     <= out_rf_next;
        end
    end

    // Next state, memory control and results.
    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        used_head_next  = used_head_reg;
        blocks_next     = blocks_reg;
        rel_idx_next    = rel_idx_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        prior_next      = prior_reg;
        step_next       = step_reg;
        rf_next         = rf_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_rf_next     = out_rf_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = NULL_LINK;
        mem_raddr       = '0;
        in_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    rel_idx_next    = release_index;
                    rf_next         = 1'b0;
                    res_entry_next  = '0;
                    res_status_next = STATUS_OK;
                    if (opcode_t'(opcode) == OP_ALLOC)
                    begin
                        if (!free_head_reg[IDX_W])
                        begin
                            // Pop straight away; the link arrives next cycle.
                            mem_raddr  = free_head_reg[IDX_W-1:0];
                            state_next = ST_POP_WR;
                        end
                        else if (blocks_reg >= BLK_W'(USABLE_BLOCKS))
                        begin
                            res_status_next = STATUS_EXHAUSTED;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            slot_next  = IDX_W'(32'(blocks_reg) * ENTRIES_PER_BLOCK);
                            cnt_next   = '0;
                            state_next = ST_REFILL;
                        end
                    end
                    else if (!used_head_reg[IDX_W]
                             && used_head_reg[IDX_W-1:0] == release_index)
                    begin
                        mem_raddr  = release_index;
                        state_next = ST_REL_HEAD_WR;
                    end
                    else if (used_head_reg[IDX_W])
                    begin
                        res_status_next = STATUS_NOT_IN_USE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        mem_raddr  = used_head_reg[IDX_W-1:0];
                        prior_next = used_head_reg;
                        step_next  = '0;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_REFILL:
            begin
                // Link one slot per cycle onto the free head.
                mem_we         = 1'b1;
                mem_waddr      = slot_reg;
                mem_wdata      = free_head_reg;
                free_head_next = link_t'(slot_reg);
                slot_next      = slot_reg + IDX_W'(1);
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ENTRIES_PER_BLOCK - 1))
                begin
                    blocks_next = blocks_reg + BLK_W'(1);
                    rf_next     = 1'b1;
                    state_next  = ST_POP_RD;
                end
            end

            ST_POP_RD:
            begin
                mem_raddr  = free_head_reg[IDX_W-1:0];
                state_next = ST_POP_WR;
            end

            ST_POP_WR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = free_head_reg[IDX_W-1:0];
                mem_wdata      = used_head_reg;
                free_head_next = nx;
                used_head_next = link_t'(free_head_reg[IDX_W-1:0]);
                res_entry_next = free_head_reg[IDX_W-1:0];
                state_next     = ST_DONE;
            end

            ST_REL_HEAD_WR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = rel_idx_reg;
                mem_wdata      = free_head_reg;
                used_head_next = nx;
                free_head_next = link_t'(rel_idx_reg);
                res_entry_next = rel_idx_reg;
                state_next     = ST_DONE;
            end

            ST_WALK:
            begin
                // The read data holds the link of the prior entry.
                if (!nx[IDX_W] && nx[IDX_W-1:0] == rel_idx_reg)
                begin
                    mem_raddr  = rel_idx_reg;
                    state_next = ST_UNLINK_WR;
                end
                else
                begin
                    prior_next = nx;
                    step_next  = step_inc;
                    if (nx[IDX_W] || step_inc == STEP_W'(POOL_SIZE))
                    begin
                        res_status_next = STATUS_NOT_IN_USE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        mem_raddr = nx[IDX_W-1:0];
                    end
                end
            end

            ST_UNLINK_WR:
            begin
                // Bridge the prior entry over the released one.
                mem_we     = 1'b1;
                mem_waddr  = prior_reg[IDX_W-1:0];
                mem_wdata  = nx;
                state_next = ST_UNLINK_FIN;
            end

            ST_UNLINK_FIN:
            begin
                mem_we         = 1'b1;
                mem_waddr      = rel_idx_reg;
                mem_wdata      = free_head_reg;
                free_head_next = link_t'(rel_idx_reg);
                res_entry_next = rel_idx_reg;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = res_entry_reg;
                    out_status_next = res_status_reg;
                    out_rf_next     = rf_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_entry_reg;
    assign status      = out_status_reg;
    assign refilled    = out_rf_reg;

    // An error result carries entry zero and no refill.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> entry_index == '0 && !refilled)
        else $error("error result carries an entry or a refill");

    // A pop never starts from an empty free list.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP_WR |-> !free_head_reg[IDX_W])
        else $error("pop from an empty free list");

    // The walk only follows a real entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> !prior_reg[IDX_W])
        else $error("walk past the end of the in-use list");

    // The block counter never passes the usable limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        blocks_reg <= BLK_W'(USABLE_BLOCKS))
        else $error("block counter beyond usable blocks");

endmodule

@@ bench/pool_alloc_checker.sv @@
// ============================================================================
// Entry pool allocator checker
// Watches the request and result channels, keeps its own copy of the free and
// in-use lists, and compares every result transaction with the predicted grant.
// ============================================================================
`timescale 1ns / 1ps

module pool_alloc_checker
    import repa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       opcode,
    input  idx_t       release_index,
    input  logic       out_valid,
    input  logic       out_ready,
    input  idx_t       entry_index,
    input  logic [1:0] status,
    input  logic       refilled,
    output int         mismatches,
    output int         awaiting
);

    // One predicted result transaction.
    typedef struct packed {
        idx_t    idx;
        status_t code;
        logic    refill;
    } grant_t;

    // Shadow of the pool: link store, list heads and the block counter.
    link_t            link_mem [POOL_SIZE];
    link_t            free_top;
    link_t            used_top;
    logic [BLK_W-1:0] blocks_out;
    grant_t           pending_grants[$];

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            link_mem[i] = '0;
        end
    end

    // Applies one request to the shadow lists and returns the grant it produces.
    task automatic compute_grant(input opcode_t op, input idx_t target, output grant_t g);
        idx_t  slot;
        link_t walk;
        link_t nxt;
        logic  found;
        int    steps;
        g = '{idx: '0, code: STATUS_OK, refill: 1'b0};
        if (op == OP_ALLOC)
        begin
            if (free_top[IDX_W] && blocks_out >= USABLE_BLOCKS)
            begin
                g.code = STATUS_EXHAUSTED;
            end
            else
            begin
                // Link in the next block, lowest slot first, so its last slot ends on top.
                if (free_top[IDX_W])
                begin
                    for (int i = 0; i < ENTRIES_PER_BLOCK; i++)
                    begin
                        slot = idx_t'(int'(blocks_out) * ENTRIES_PER_BLOCK + i);
                        link_mem[slot] = free_top;
                        free_top = {1'b0, slot};
                    end
                    blocks_out = blocks_out + 1'b1;
                    g.refill = 1'b1;
                end
                slot = free_top[IDX_W-1:0];
                free_top = link_mem[slot];
                link_mem[slot] = used_top;
                used_top = {1'b0, slot};
                g.idx = slot;
            end
        end
        else if (!used_top[IDX_W] && used_top[IDX_W-1:0] == target)
        begin
            // The target sits at the head of the in-use list.
            used_top = link_mem[target];
            link_mem[target] = free_top;
            free_top = {1'b0, target};
            g.idx = target;
        end
        else
        begin
            // Walk the in-use list looking for the link that points at the target.
            walk = used_top;
            found = 1'b0;
            for (steps = 0; steps < POOL_SIZE && !walk[IDX_W] && !found; steps++)
            begin
                nxt = link_mem[walk[IDX_W-1:0]];
                if (!nxt[IDX_W] && nxt[IDX_W-1:0] == target)
                begin
                    link_mem[walk[IDX_W-1:0]] = link_mem[target];
                    link_mem[target] = free_top;
                    free_top = {1'b0, target};
                    found = 1'b1;
                end
                else
                begin
                    walk = nxt;
                end
            end
            if (found)
                g.idx = target;
            else
                g.code = STATUS_NOT_IN_USE;
        end
    endtask

    // Compare completed results first, then predict the request taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        grant_t want;
        grant_t got;
        if (!rst_n)
        begin
            free_top   = NULL_LINK;
            used_top   = NULL_LINK;
            blocks_out = '0;
            pending_grants.delete();
            mismatches = 0;
            awaiting   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $error("result transaction with no request outstanding: entry %0d",
                           entry_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (entry_index !== want.idx)
                    begin
                        $error("entry_index mismatch: expected %0d, actual %0d",
                               want.idx, entry_index);
                        mismatches++;
                    end
                    if (status !== want.code)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.code, status);
                        mismatches++;
                    end
                    if (refilled !== want.refill)
                    begin
                        $error("refilled mismatch: expected %0d, actual %0d",
                               want.refill, refilled);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                compute_grant(opcode_t'(opcode), release_index, got);
                pending_grants.push_back(got);
            end
            awaiting = pending_grants.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ============================================================================
// Entry pool allocator testbench
// Drives allocate and release transactions with random gaps and stalls,
// and reports the checker's verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import repa_pkg::*;

    localparam int RANDOM_ITEMS = 370;
    localparam int TAIL_ALLOCS  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int TOP_SLOT     = ENTRIES_PER_BLOCK - 1;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    idx_t       release_index;
    logic       out_valid;
    logic       out_ready;
    idx_t       entry_index;
    logic [1:0] status;
    logic       refilled;

    int         mismatches;
    int         awaiting;
    int         results_seen = 0;
    logic       steady = 1'b0;
    logic       backpressure_done = 1'b0;
    opcode_t    issued_ops[$];
    idx_t       live_entries[$];
    idx_t       freed_entries[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    root_entry_pool_allocator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .release_index (release_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .entry_index   (entry_index),
        .status        (status),
        .refilled      (refilled)
    );

    pool_alloc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .release_index (release_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .entry_index   (entry_index),
        .status        (status),
        .refilled      (refilled),
        .mismatches    (mismatches),
        .awaiting      (awaiting)
    );

    // Offers one request transaction, after an optional gap, and waits for it to be taken.
    task automatic send_request(input opcode_t op, input idx_t target);
        int gap;
        int hit;
        gap = 0;
        hit = -1;
        if (!steady && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        release_index <= target;
        do @(posedge clk); while (!in_ready);
        issued_ops.push_back(op);
        if (op == OP_RELEASE)
        begin
            foreach (live_entries[i])
            begin
                if (hit < 0 && live_entries[i] == target)
                    hit = i;
            end
            if (hit >= 0)
                live_entries.delete(hit);
            freed_entries.push_back(target);
            if (freed_entries.size() > 16)
                void'(freed_entries.pop_front());
        end
    endtask

    // Releases an entry known to be allocated, or a random index when none is known.
    task automatic release_live_entry();
        idx_t pick;
        if (live_entries.size() != 0)
            pick = live_entries[$urandom_range(0, live_entries.size() - 1)];
        else
            pick = idx_t'($urandom);
        send_request(OP_RELEASE, pick);
    endtask

    // Tracks which entries the block has handed out, to steer later releases.
    always @(posedge clk)
    begin : track_results
        opcode_t op;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (issued_ops.size() != 0)
            begin
                op = issued_ops.pop_front();
                if (op == OP_ALLOC && status == STATUS_OK)
                    live_entries.push_back(entry_index);
            end
        end
    end

    // Result side: random stalls, one long hold-off so the block backs up its input.
    initial
    begin : result_sink
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!backpressure_done && results_seen >= 200)
            begin
                backpressure_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Request side: directed cases, random mix, then a burst of allocates.
    initial
    begin : request_source
        int alloc_pct;
        idx_t again;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opcode        <= OP_ALLOC;
        release_index <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First block comes in on the first allocate; its top slots come out in order.
        send_request(OP_ALLOC, '1);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, idx_t'(10'h2AA));
        send_request(OP_ALLOC, idx_t'(10'h155));
        // Release from the middle, the head and the tail of the in-use list.
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 2));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 3));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT));
        // Releases of entries that are not in use.
        send_request(OP_RELEASE, idx_t'(TOP_SLOT));
        send_request(OP_RELEASE, '1);
        send_request(OP_RELEASE, '0);
        send_request(OP_RELEASE, idx_t'(10'h2AA));
        send_request(OP_RELEASE, idx_t'(10'h155));
        // Released entries come back first, then fresh ones.
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '1);
        // Empty the in-use list completely, then release into an empty list.
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 1));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 3));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 2));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 4));
        send_request(OP_RELEASE, idx_t'(TOP_SLOT - 4));

        // Random mix, alternating between growing and shrinking the in-use list.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 150 && n < 250);
            alloc_pct = ((n / 75) % 2 == 0) ? 65 : 35;
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                send_request(OP_ALLOC, idx_t'($urandom));
            end
            else if ($urandom_range(0, 99) < 85)
            begin
                release_live_entry();
            end
            else if (freed_entries.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                // Likely a second release of an entry already given back.
                send_request(OP_RELEASE,
                             freed_entries[$urandom_range(0, freed_entries.size() - 1)]);
            end
            else
            begin
                send_request(OP_RELEASE, idx_t'($urandom));
            end
        end
        steady = 1'b0;

        // A burst of allocates that pulls further blocks into the free list.
        repeat (TAIL_ALLOCS) send_request(OP_ALLOC, idx_t'($urandom));

        // Give a few entries back, release one twice, and allocate again.
        repeat (6) release_live_entry();
        again = freed_entries[freed_entries.size() - 1];
        send_request(OP_RELEASE, again);
        repeat (10) send_request(OP_ALLOC, idx_t'($urandom));
        in_valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle.
        do @(posedge clk); while (awaiting != 0);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
